// ----- rtl/gfr_pkg.sv -----
package gfr_pkg;

	localparam int GLYPH_COUNT = 25;
	localparam logic [4:0] GLYPH_NONE = 5'd25;
	localparam logic [7:0] DEGREE_CODE = 8'hB0;

	typedef enum logic [2:0] {
		MODE_CLEAR = 3'd0,
		MODE_PIXEL = 3'd1,
		MODE_CHAR  = 3'd2,
		MODE_LINE  = 3'd3,
		MODE_READ  = 3'd4
	} gfr_mode_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISPATCH,
		ST_CLEAR,
		ST_STEP,
		ST_MODIFY,
		ST_DONE
	} gfr_state_t;

	typedef struct packed {
		logic load;
		logic clr_wr;
		logic rd;
		logic wr;
		logic step;
		logic rd_byte;
		logic res_load;
	} gfr_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       empty;
		logic       clip;
		logic       last;
		logic       clr_last;
		logic       out_free;
	} gfr_stat_t;

	// 5x7 font, seven bits per column, top row in bit 0
	localparam logic [6:0] GLYPH_ROM [0:GLYPH_COUNT-1][0:4] = '{
		'{7'h00, 7'h00, 7'h00, 7'h00, 7'h00}, // space
		'{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E}, // 0
		'{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00}, // 1
		'{7'h42, 7'h61, 7'h51, 7'h49, 7'h46}, // 2
		'{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31}, // 3
		'{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10}, // 4
		'{7'h27, 7'h45, 7'h45, 7'h45, 7'h39}, // 5
		'{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30}, // 6
		'{7'h01, 7'h71, 7'h09, 7'h05, 7'h03}, // 7
		'{7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, // 8
		'{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E}, // 9
		'{7'h00, 7'h00, 7'h60, 7'h60, 7'h00}, // period
		'{7'h0C, 7'h12, 7'h12, 7'h0C, 7'h00}, // degree
		'{7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E}, // A
		'{7'h3E, 7'h41, 7'h41, 7'h41, 7'h22}, // C
		'{7'h7F, 7'h09, 7'h09, 7'h09, 7'h01}, // F
		'{7'h3E, 7'h41, 7'h49, 7'h49, 7'h3A}, // G
		'{7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F}, // H
		'{7'h7F, 7'h08, 7'h14, 7'h22, 7'h41}, // K
		'{7'h7F, 7'h40, 7'h40, 7'h40, 7'h40}, // L
		'{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}, // O
		'{7'h7F, 7'h09, 7'h09, 7'h09, 7'h06}, // P
		'{7'h26, 7'h49, 7'h49, 7'h49, 7'h32}, // S
		'{7'h01, 7'h01, 7'h7F, 7'h01, 7'h01}, // T
		'{7'h7C, 7'h02, 7'h01, 7'h02, 7'h7C}  // V
	};

	function automatic logic [4:0] glyph_index(input logic [7:0] code);
		logic [4:0] g;
		g = GLYPH_NONE;
		if (code inside {[8'h30:8'h39]}) begin
			g = 5'(code - 8'h30) + 5'd1;
		end else begin
			case (code)
				8'h20:       g = 5'd0;  // space
				8'h2E:       g = 5'd11; // period
				DEGREE_CODE: g = 5'd12;
				8'h41:       g = 5'd13; // A
				8'h43:       g = 5'd14; // C
				8'h46:       g = 5'd15; // F
				8'h47:       g = 5'd16; // G
				8'h48:       g = 5'd17; // H
				8'h4B:       g = 5'd18; // K
				8'h4C:       g = 5'd19; // L
				8'h4F:       g = 5'd20; // O
				8'h50:       g = 5'd21; // P
				8'h53:       g = 5'd22; // S
				8'h54:       g = 5'd23; // T
				8'h56:       g = 5'd24; // V
				default:     g = GLYPH_NONE;
			endcase
		end
		return g;
	endfunction

	function automatic logic [6:0] glyph_column(input logic [4:0] g, input logic [2:0] c);
		logic [6:0] bits;
		bits = '0;
		if (g < 5'(GLYPH_COUNT) && c < 3'd5) begin
			bits = GLYPH_ROM[g][c];
		end
		return bits;
	endfunction

endpackage

// ----- rtl/gfr_ctrl.sv -----
module gfr_ctrl import gfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  gfr_stat_t stat,
	output gfr_cmd_t  cmd
);

	gfr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (stat.mode)
					MODE_CLEAR: state_d = ST_CLEAR;
					MODE_PIXEL, MODE_CHAR, MODE_LINE: begin
						state_d = stat.empty ? ST_DONE : ST_STEP;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_DONE;
			end
			ST_STEP: begin
				if (!stat.clip) state_d = ST_MODIFY;
				else if (stat.last) state_d = ST_DONE;
			end
			ST_MODIFY: begin
				state_d = stat.last ? ST_DONE : ST_STEP;
			end
			ST_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DISPATCH: cmd.rd_byte = (stat.mode == MODE_READ);
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_STEP: begin
				// skip clipped positions without touching the store
				cmd.rd = !stat.clip;
				cmd.step = stat.clip;
			end
			ST_MODIFY: begin
				cmd.wr = 1'b1;
				cmd.step = 1'b1;
			end
			ST_DONE: cmd.res_load = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- rtl/gfr_datapath.sv -----
module gfr_datapath import gfr_pkg::*; #(
	parameter int SCREEN_WIDTH = 128,
	parameter int SCREEN_HEIGHT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  gfr_cmd_t    cmd,
	output gfr_stat_t   stat,
	input  logic [2:0]  in_mode,
	input  logic [7:0]  in_x,
	input  logic [5:0]  in_y,
	input  logic [7:0]  in_x_end,
	input  logic [7:0]  in_char_code,
	input  logic        in_large_req,
	input  logic        in_pixel_on,
	input  logic [8:0]  in_byte_index,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [15:0] out_data
);

	localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int AW = $clog2(STORE_BYTES);

	logic [7:0] mem [STORE_BYTES];

	logic [2:0]    mode_q;
	logic [7:0]    x_q;
	logic [5:0]    y_q;
	logic          large_q;
	logic          on_q;
	logic [4:0]    glyph_q;
	logic          byte_ok_q;
	logic [AW-1:0] byte_addr_q;
	logic [8:0]    col_q, col_end_q;
	logic [3:0]    page_q, page_start_q, page_end_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    rdata_q;
	logic          out_valid_q;
	logic [15:0]   out_data_q;

	logic [8:0]    col_end_d;
	logic [3:0]    page_end_d;
	logic [AW-1:0] pos_addr;
	logic [AW-1:0] rd_addr;
	logic [3:0]    k;
	logic [2:0]    gi;
	logic [6:0]    col_bits;
	logic [13:0]   pattern;
	logic [31:0]   shifted;
	logic [1:0]    j;
	logic [7:0]    page_bits;
	logic [7:0]    row_mask;
	logic [7:0]    bits;
	logic [7:0]    new_byte;
	logic [7:0]    res_read;
	logic          res_known;

	always_comb begin
		case (in_mode)
			MODE_LINE: col_end_d = {1'b0, in_x_end};
			MODE_CHAR: col_end_d = {1'b0, in_x} + (in_large_req ? 9'd9 : 9'd4);
			default:   col_end_d = {1'b0, in_x};
		endcase
		if (in_mode == MODE_CHAR) begin
			page_end_d = 4'(({1'b0, in_y} + (in_large_req ? 7'd13 : 7'd6)) >> 3);
		end else begin
			page_end_d = {1'b0, in_y[5:3]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q       <= in_mode;
			x_q          <= in_x;
			y_q          <= in_y;
			large_q      <= in_large_req;
			on_q         <= in_pixel_on;
			glyph_q      <= glyph_index(in_char_code);
			byte_ok_q    <= {23'd0, in_byte_index} < 32'(STORE_BYTES);
			byte_addr_q  <= AW'(in_byte_index);
			col_q        <= {1'b0, in_x};
			col_end_q    <= col_end_d;
			page_q       <= {1'b0, in_y[5:3]};
			page_start_q <= {1'b0, in_y[5:3]};
			page_end_q   <= page_end_d;
		end else if (cmd.step) begin
			// pages inner, columns outer
			if (page_q == page_end_q) begin
				page_q <= page_start_q;
				col_q  <= col_q + 9'd1;
			end else begin
				page_q <= page_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= stat.clr_last ? '0 : clr_q + AW'(1);
		end
	end

	assign pos_addr = AW'(32'(page_q) * SCREEN_WIDTH + 32'(col_q));
	assign rd_addr = cmd.rd_byte ? byte_addr_q : pos_addr;

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[clr_q] <= '0;
		end else if (cmd.wr) begin
			mem[pos_addr] <= new_byte;
		end
		if (cmd.rd || cmd.rd_byte) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// glyph column under the current screen column, stretched for 2x
	always_comb begin
		k = 4'(col_q - {1'b0, x_q});
		gi = large_q ? k[3:1] : k[2:0];
		col_bits = glyph_column(glyph_q, gi);
		if (mode_q == MODE_CHAR) begin
			if (large_q) begin
				for (int r = 0; r < 7; r++) begin
					pattern[2*r]   = col_bits[r];
					pattern[2*r+1] = col_bits[r];
				end
			end else begin
				pattern = {7'd0, col_bits};
			end
		end else begin
			pattern = 14'd1;
		end
		shifted = 32'(pattern) << y_q[2:0];
		j = 2'(page_q - page_start_q);
		page_bits = shifted[{j, 3'b000} +: 8];
		for (int b = 0; b < 8; b++) begin
			row_mask[b] = {page_q, 3'(b)} < 7'(SCREEN_HEIGHT);
		end
		bits = page_bits & row_mask;
		if (mode_q == MODE_PIXEL && !on_q) begin
			new_byte = rdata_q & ~bits;
		end else begin
			new_byte = rdata_q | bits;
		end
	end

	assign res_read = (mode_q == MODE_READ && byte_ok_q) ? rdata_q : 8'd0;
	assign res_known = (mode_q == MODE_CHAR) && (glyph_q != GLYPH_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_data_q <= {7'd0, res_known, res_read};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		stat.mode = mode_q;
		stat.empty = (col_end_q < col_q) || ((mode_q == MODE_CHAR) && (glyph_q == GLYPH_NONE));
		stat.clip = (col_q >= 9'(SCREEN_WIDTH)) || (page_q >= 4'(PAGE_COUNT));
		stat.last = (col_q == col_end_q) && (page_q == page_end_q);
		stat.clr_last = (clr_q == AW'(STORE_BYTES - 1));
		stat.out_free = !out_valid_q || out_ready;
	end

endmodule

// ----- rtl/glyph_framebuffer_renderer_unit.sv -----
// channel  | dir | tdata fields (low bit up)                        | tuser
// ---------+-----+--------------------------------------------------+------
// s_axis   | in  | x[7:0] y[13:8] x_end[21:14] char_code[29:22]     | mode
//          |     | large_req[30] pixel_on[31] byte_index[40:32]     |
// m_axis   | out | read_data[7:0] glyph_known[8]                    | -
//
// One word in, one word out. Each word takes IDLE, DISPATCH, DONE and its work:
// read none, pixel/line/character a read and write per byte touched and a skip per
// clipped column/page, clear a write per byte (SCREEN_WIDTH * pages, 512 at default).
// The single-port frame store sets the read-modify-write pace.
// After reset the store is swept to zero, one byte a cycle, before s_tready rises.
// A result waiting on m_tready does not block the next input word; a second one does.
module glyph_framebuffer_renderer_unit import gfr_pkg::*; #(
	parameter int SCREEN_WIDTH = 128,
	parameter int SCREEN_HEIGHT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // x, y, x_end, char_code, large_req, pixel_on, byte_index
	input  logic [2:0]  s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // read_data, glyph_known
);

	gfr_cmd_t  cmd;
	gfr_stat_t stat;

	gfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gfr_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_mode       (s_tuser),
		.in_x          (s_tdata[7:0]),
		.in_y          (s_tdata[13:8]),
		.in_x_end      (s_tdata[21:14]),
		.in_char_code  (s_tdata[29:22]),
		.in_large_req  (s_tdata[30]),
		.in_pixel_on   (s_tdata[31]),
		.in_byte_index (s_tdata[40:32]),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_data      (m_tdata)
	);

endmodule

// ----- test/glyph_framebuffer_renderer_unit_test.sv -----
module glyph_framebuffer_renderer_unit_test;
	import gfr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCREEN_WIDTH = 128;
	localparam int SCREEN_HEIGHT = 32;
	localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
	localparam int FONT_SIZE = 25;
	localparam int NO_GLYPH = FONT_SIZE;
	localparam int RANDOM_WORDS = 1775;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int DRAIN_CYCLES = 64;
	localparam int PRESSURE_AFTER = 700;
	localparam int PRESSURE_CYCLES = 500;
	localparam int REPORT_MAX = 10;
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam logic [7:0] CODE_SPACE = 8'h20;
	localparam logic [7:0] CODE_ZERO = 8'h30;
	localparam logic [7:0] CODE_K = 8'h4B;
	localparam logic [7:0] CODE_DEGREE = 8'hB0;
	localparam logic [7:0] CODE_BAD_HI = 8'hFF;
	localparam logic [7:0] CODE_BAD_MID = 8'h80;

	// character codes in font order, the slot is the index
	localparam logic [7:0] FONT_CODES [0:FONT_SIZE-1] = '{
		8'h20, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
		8'h2E, 8'hB0, 8'h41, 8'h43, 8'h46, 8'h47, 8'h48, 8'h4B, 8'h4C, 8'h4F, 8'h50,
		8'h53, 8'h54, 8'h56
	};

	// seven bits per glyph column, top row in bit 0
	localparam logic [6:0] FONT_BITS [0:FONT_SIZE-1][0:4] = '{
		'{7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
		'{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E},
		'{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
		'{7'h42, 7'h61, 7'h51, 7'h49, 7'h46},
		'{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31},
		'{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10},
		'{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
		'{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30},
		'{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
		'{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},
		'{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E},
		'{7'h00, 7'h00, 7'h60, 7'h60, 7'h00},
		'{7'h0C, 7'h12, 7'h12, 7'h0C, 7'h00},
		'{7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E},
		'{7'h3E, 7'h41, 7'h41, 7'h41, 7'h22},
		'{7'h7F, 7'h09, 7'h09, 7'h09, 7'h01},
		'{7'h3E, 7'h41, 7'h49, 7'h49, 7'h3A},
		'{7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F},
		'{7'h7F, 7'h08, 7'h14, 7'h22, 7'h41},
		'{7'h7F, 7'h40, 7'h40, 7'h40, 7'h40},
		'{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E},
		'{7'h7F, 7'h09, 7'h09, 7'h09, 7'h06},
		'{7'h26, 7'h49, 7'h49, 7'h49, 7'h32},
		'{7'h01, 7'h01, 7'h7F, 7'h01, 7'h01},
		'{7'h7C, 7'h02, 7'h01, 7'h02, 7'h7C}
	};

	typedef struct packed {
		logic [8:0] byte_index;
		logic       pixel_on;
		logic       large_req;
		logic [7:0] char_code;
		logic [7:0] x_end;
		logic [5:0] y;
		logic [7:0] x;
	} draw_word_t;

	localparam int WORD_BITS = $bits(draw_word_t);

	typedef struct packed {
		logic [7:0] read_data;
		logic       glyph_known;
	} frame_result_t;

	class frame_scoreboard;
		logic [7:0] frame [STORE_BYTES];
		frame_result_t result_q[$];
		int checked;
		int errors;

		function new();
			checked = 0;
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (frame[i]) frame[i] = '0;
		endfunction

		function void plot(int col, int row, bit on);
			int addr;
			if (col >= SCREEN_WIDTH || row >= SCREEN_HEIGHT) return;
			addr = (row / 8) * SCREEN_WIDTH + col;
			frame[addr][row % 8] = on;
		endfunction

		function int glyph_slot(logic [7:0] code);
			for (int i = 0; i < FONT_SIZE; i++)
				if (FONT_CODES[i] == code) return i;
			return NO_GLYPH;
		endfunction

		function void stamp_glyph(int left, int top, int slot, bit big);
			int scale;
			scale = big ? 2 : 1;
			for (int col = 0; col < 5; col++)
				for (int row = 0; row < 7; row++)
					if (FONT_BITS[slot][col][row])
						for (int sx = 0; sx < scale; sx++)
							for (int sy = 0; sy < scale; sy++)
								plot(left + col * scale + sx, top + row * scale + sy, 1'b1);
		endfunction

		// apply one accepted word to the frame copy and queue its result
		function void note_word(logic [2:0] mode, draw_word_t w);
			frame_result_t r;
			int slot;
			int c;
			r = '0;
			case (mode)
				MODE_CLEAR: wipe();
				MODE_PIXEL: plot(w.x, w.y, w.pixel_on);
				MODE_CHAR: begin
					slot = glyph_slot(w.char_code);
					if (slot != NO_GLYPH) begin
						r.glyph_known = 1'b1;
						stamp_glyph(w.x, w.y, slot, w.large_req);
					end
				end
				MODE_LINE: begin
					for (c = w.x; c <= int'(w.x_end); c++) plot(c, w.y, 1'b1);
				end
				MODE_READ: begin
					if (w.byte_index < STORE_BYTES) r.read_data = frame[w.byte_index];
				end
				default: ;
			endcase
			result_q.push_back(r);
		endfunction

		function void flag(string what, int want, int got);
			errors++;
			if (errors <= REPORT_MAX)
				$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
		endfunction

		function void check_result(logic [15:0] data);
			frame_result_t want;
			if (result_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: result word 0x%0h arrived with nothing pending", $time, data);
				return;
			end
			want = result_q.pop_front();
			checked++;
			if (data[7:0] !== want.read_data) flag("read_data", want.read_data, data[7:0]);
			if (data[8] !== want.glyph_known) flag("glyph_known", want.glyph_known, data[8]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	frame_scoreboard sb;
	int words_sent;
	int mode_seen [8];
	bit sender_busy;

	glyph_framebuffer_renderer_unit #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles", cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// receiver: phases of steady ready, random stalls, and one long hold-off
	initial begin
		int stall_left;
		int hold_left;
		int phase_left;
		int style;
		bit pressure_done;
		logic ready;
		m_tready = 1'b0;
		stall_left = 0;
		hold_left = 0;
		phase_left = 0;
		style = 0;
		pressure_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (phase_left == 0) begin
				style = $urandom_range(0, 2);
				phase_left = $urandom_range(100, 300);
			end
			phase_left--;
			if (!pressure_done && words_sent >= PRESSURE_AFTER) begin
				pressure_done = 1;
				hold_left = PRESSURE_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				ready = 1'b0;
			end else begin
				ready = 1'b1;
				if (style == 1 && $urandom_range(0, 99) < 30) stall_left = pick_gap();
				if (style == 2 && $urandom_range(0, 99) < 70) stall_left = pick_gap() + 1;
			end
			m_tready <= ready;
		end
	end

	task automatic send_word(input logic [2:0] mode, input draw_word_t w);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {7'b0, w};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_word(mode, w);
		mode_seen[mode]++;
		words_sent++;
		gap = sender_busy ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic draw_word_t make_word(int x, int y, int x_end, logic [7:0] code,
			bit big, bit on, int idx);
		draw_word_t w;
		w.x = 8'(x);
		w.y = 6'(y);
		w.x_end = 8'(x_end);
		w.char_code = code;
		w.large_req = big;
		w.pixel_on = on;
		w.byte_index = 9'(idx);
		return w;
	endfunction

	function automatic int pick_col();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 135);
	endfunction

	function automatic int pick_row();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 35);
	endfunction

	task automatic random_word(output logic [2:0] mode, output draw_word_t w);
		int r;
		w = WORD_BITS'({$urandom, $urandom});
		r = $urandom_range(0, 99);
		if (r < 3) begin
			mode = MODE_CLEAR;
		end else if (r < 18) begin
			mode = MODE_PIXEL;
			w.x = 8'(pick_col());
			w.y = 6'(pick_row());
		end else if (r < 45) begin
			mode = MODE_CHAR;
			w.x = 8'(pick_col());
			w.y = 6'(pick_row());
			w.large_req = ($urandom_range(0, 9) < 4);
			if ($urandom_range(0, 9) < 8)
				w.char_code = FONT_CODES[$urandom_range(0, FONT_SIZE - 1)];
		end else if (r < 62) begin
			mode = MODE_LINE;
			w.x = 8'(pick_col());
			w.y = 6'(pick_row());
			if ($urandom_range(0, 9) != 0) w.x_end = 8'(w.x + $urandom_range(0, 40));
		end else if (r < 96) begin
			mode = MODE_READ;
		end else begin
			mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
		end
	endtask

	initial begin
		logic [2:0] mode;
		draw_word_t w;
		int spare_seen;
		sb = new();
		words_sent = 0;
		foreach (mode_seen[i]) mode_seen[i] = 0;
		sender_busy = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_word(MODE_READ, make_word(0, 0, 0, CODE_SPACE, 0, 0, 0));
		send_word(MODE_PIXEL, make_word(0, 0, 0, CODE_SPACE, 0, 1, 0));
		send_word(MODE_READ, make_word(0, 0, 0, CODE_SPACE, 0, 0, 0));
		send_word(MODE_PIXEL, make_word(127, 31, 0, CODE_SPACE, 0, 1, 0));
		send_word(MODE_READ, make_word(0, 0, 0, CODE_SPACE, 0, 0, 511));
		// off-screen pixels must leave the store untouched
		send_word(MODE_PIXEL, make_word(255, 63, 255, CODE_BAD_HI, 1, 1, 511));
		send_word(MODE_PIXEL, make_word(128, 5, 0, CODE_SPACE, 0, 1, 0));
		send_word(MODE_PIXEL, make_word(5, 32, 0, CODE_SPACE, 0, 1, 0));
		send_word(MODE_PIXEL, make_word(0, 0, 0, CODE_SPACE, 0, 0, 0));
		send_word(MODE_READ, make_word(0, 0, 0, CODE_SPACE, 0, 0, 0));
		send_word(MODE_CHAR, make_word(0, 0, 0, CODE_ZERO, 0, 0, 0));
		send_word(MODE_READ, make_word(0, 0, 0, CODE_SPACE, 0, 0, 1));
		// double-size glyph clipped at the lower right corner
		send_word(MODE_CHAR, make_word(120, 28, 0, CODE_K, 1, 0, 0));
		send_word(MODE_READ, make_word(0, 0, 0, CODE_SPACE, 0, 0, 3 * SCREEN_WIDTH + 121));
		send_word(MODE_CHAR, make_word(20, 8, 0, CODE_DEGREE, 0, 0, 0));
		send_word(MODE_READ, make_word(0, 0, 0, CODE_SPACE, 0, 0, SCREEN_WIDTH + 21));
		send_word(MODE_CHAR, make_word(40, 0, 0, CODE_BAD_HI, 1, 1, 0));
		send_word(MODE_CHAR, make_word(50, 0, 0, CODE_BAD_MID, 0, 0, 0));
		send_word(MODE_LINE, make_word(0, 31, 255, CODE_SPACE, 0, 0, 0));
		send_word(MODE_READ, make_word(0, 0, 0, CODE_SPACE, 0, 0, 3 * SCREEN_WIDTH + 64));
		// reversed line draws nothing
		send_word(MODE_LINE, make_word(10, 0, 5, CODE_SPACE, 0, 0, 0));
		send_word(MODE_SPARE_LO, make_word(3, 3, 9, CODE_ZERO, 1, 1, 1));
		send_word(MODE_SPARE_HI, make_word(255, 63, 255, CODE_BAD_HI, 1, 1, 511));
		send_word(MODE_CLEAR, make_word(0, 0, 0, CODE_SPACE, 0, 0, 0));
		send_word(MODE_READ, make_word(0, 0, 0, CODE_SPACE, 0, 0, 3 * SCREEN_WIDTH + 121));

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 100 == 0) sender_busy = ($urandom_range(0, 3) == 0);
			random_word(mode, w);
			send_word(mode, w);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (sb.result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		spare_seen = 0;
		for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) spare_seen += mode_seen[m];
		$display("Sent %0d words: %0d clear, %0d pixel, %0d char, %0d line, %0d read, %0d spare",
			words_sent, mode_seen[MODE_CLEAR], mode_seen[MODE_PIXEL], mode_seen[MODE_CHAR],
			mode_seen[MODE_LINE], mode_seen[MODE_READ], spare_seen);
		$display("Checked %0d results, %0d errors, %0d results never arrived",
			sb.checked, sb.errors, sb.result_q.size());
		if (sb.errors == 0 && sb.result_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
